>>> rtl/mau_pkg.sv
// shared types and constants of the modular arithmetic unit
package mau_pkg;

    localparam int unsigned MOD_W = 31;
    localparam int unsigned OPA_W = 32;
    localparam int unsigned KIND_W = 3;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd998244353;

    typedef enum logic [KIND_W-1:0] {
        KIND_REDUCE = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_DIV    = 3'd4,
        KIND_INV    = 3'd5,
        KIND_NEG    = 3'd6,
        KIND_POW    = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_PREP,
        ST_EXP_MUL,
        ST_EXP_SQR,
        ST_FINAL_MUL,
        ST_DONE
    } state_t;

endpackage

>>> rtl/mau_rem.sv
// bit-serial remainder of a 32-bit magnitude by the modulus, one bit a cycle
module mau_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mau_pkg::OPA_W-1:0]   value,
    input  logic [mau_pkg::MOD_W-1:0]   modulus,
    output logic                        done,
    output logic [mau_pkg::MOD_W-1:0]   rem
);
    logic [mau_pkg::OPA_W-1:0] shift_reg, shift_next;
    logic [mau_pkg::MOD_W-1:0] rem_reg, rem_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [mau_pkg::MOD_W:0]   trial;

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        trial      = {rem_reg, shift_reg[mau_pkg::OPA_W-1]};
        done       = 1'b0;
        if (start)
        begin
            shift_next = value;
            rem_next   = '0;
            cnt_next   = 6'(mau_pkg::OPA_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, modulus})
                trial = trial - {1'b0, modulus};
            rem_next   = trial[mau_pkg::MOD_W-1:0];
            shift_next = {shift_reg[mau_pkg::OPA_W-2:0], 1'b0};
            cnt_next   = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign rem = rem_next;
endmodule

>>> rtl/mau_mul.sv
// bit-serial modular multiplier, msb-first double-and-add, one bit a cycle
module mau_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mau_pkg::MOD_W-1:0]   x,
    input  logic [mau_pkg::MOD_W-1:0]   y,
    input  logic [mau_pkg::MOD_W-1:0]   modulus,
    output logic                        done,
    output logic [mau_pkg::MOD_W-1:0]   prod
);
    logic [mau_pkg::MOD_W-1:0] x_reg, x_next;
    logic [mau_pkg::MOD_W-1:0] y_reg, y_next;
    logic [mau_pkg::MOD_W-1:0] acc_reg, acc_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [mau_pkg::MOD_W+1:0] dbl, sum;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        // operands are residues below modulus, so one subtract suffices per step
        dbl = {2'b00, acc_reg} + {2'b00, acc_reg};
        if (dbl >= {2'b00, modulus})
            dbl = dbl - {2'b00, modulus};
        sum = dbl;
        if (x_reg[mau_pkg::MOD_W-1])
            sum = dbl + {2'b00, y_reg};
        if (sum >= {2'b00, modulus})
            sum = sum - {2'b00, modulus};
        if (start)
        begin
            x_next    = x;
            y_next    = y;
            acc_next  = '0;
            cnt_next  = 6'(mau_pkg::MOD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[mau_pkg::MOD_W-1:0];
            x_next   = {x_reg[mau_pkg::MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_next;
endmodule

>>> rtl/modular_arithmetic_unit.sv
// top level of the modular arithmetic unit
// Each accepted word runs to completion before the next is taken. Operand a
// (signed) and operand b are first reduced by a bit-serial remainder unit.
// Add, sub, negate and reduce then finish in the prep state. Mul adds one
// pass of the bit-serial modular multiplier. Power, inverse and divide run
// square-and-multiply over 31 exponent bits on that one shared multiplier: 31
// squarings and up to 31 multiplies (one more for divide), so the run time of
// a word depends on the bits set in the exponent. The result sits in an output
// register until taken, while the next word may already be accepted and worked
// on. A modulus below two gives 0 for every kind. The modulus register is
// written with cfg_we.
module modular_arithmetic_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mau_pkg::MOD_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mau_pkg::KIND_W-1:0]  kind,
    input  logic [mau_pkg::OPA_W-1:0]   operand_a,
    input  logic [mau_pkg::MOD_W-1:0]   operand_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mau_pkg::MOD_W-1:0]   result
);
    mau_pkg::state_t state_reg, state_next;
    logic [mau_pkg::MOD_W-1:0] mod_reg;
    logic [mau_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [mau_pkg::OPA_W-1:0] opa_reg, opa_next;
    logic [mau_pkg::MOD_W-1:0] opb_reg, opb_next;
    logic [mau_pkg::MOD_W-1:0] a_reg, a_next;     // reduced a
    logic [mau_pkg::MOD_W-1:0] b_reg, b_next;     // reduced b
    logic [mau_pkg::MOD_W-1:0] acc_reg, acc_next; // power accumulator
    logic [mau_pkg::MOD_W-1:0] sq_reg, sq_next;   // running square
    logic [mau_pkg::MOD_W-1:0] exp_reg, exp_next; // exponent, shifted right
    logic [4:0]                bit_reg, bit_next; // exponent bits left
    logic [mau_pkg::MOD_W-1:0] fin_reg, fin_next; // finished value, not yet shown
    logic [mau_pkg::MOD_W-1:0] res_reg, res_next;
    logic                      oval_reg, oval_next;
    // multiplier busy tracking: set on start, cleared on done
    logic                      mbusy_reg, mbusy_next;

    logic                      rem_start, rem_done;
    logic [mau_pkg::OPA_W-1:0] rem_value;
    logic [mau_pkg::MOD_W-1:0] rem_out;
    logic                      mul_start, mul_done;
    logic [mau_pkg::MOD_W-1:0] mul_x, mul_y, mul_out;
    logic [mau_pkg::MOD_W:0]   sum_w;
    logic                      a_neg;

    assign a_neg = opa_reg[mau_pkg::OPA_W-1];

    mau_rem u_rem (
        .clk(clk), .rst_n(rst_n), .start(rem_start), .value(rem_value),
        .modulus(mod_reg), .done(rem_done), .rem(rem_out)
    );

    mau_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
        .modulus(mod_reg), .done(mul_done), .prod(mul_out)
    );

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        bit_next   = bit_reg;
        fin_next   = fin_reg;
        res_next   = res_reg;
        oval_next  = oval_reg;
        rem_start  = 1'b0;
        rem_value  = a_neg ? (~opa_reg + 32'd1) : opa_reg;
        mul_start  = 1'b0;
        mul_x      = acc_reg;
        mul_y      = sq_reg;
        sum_w      = '0;
        in_stall   = 1'b1;

        if (oval_reg && !out_stall)
            oval_next = 1'b0;

        unique case (state_reg)
            mau_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    kind_next = kind;
                    opa_next  = operand_a;
                    opb_next  = operand_b;
                    if (mod_reg < 31'd2)
                    begin
                        fin_next   = '0;
                        state_next = mau_pkg::ST_DONE;
                    end
                    else
                        state_next = mau_pkg::ST_RED_A;
                end
            end
            mau_pkg::ST_RED_A:
            begin
                // launch the remainder on entry, then wait for it
                if (!rem_done && bit_reg == 5'd0)
                begin
                    rem_start = 1'b1;
                    bit_next  = 5'd1;
                end
                else if (rem_done)
                begin
                    bit_next = 5'd0;
                    if (a_neg && rem_out != '0)
                        a_next = mod_reg - rem_out;
                    else
                        a_next = rem_out;
                    state_next = mau_pkg::ST_RED_B;
                end
            end
            mau_pkg::ST_RED_B:
            begin
                rem_value = {1'b0, opb_reg};
                if (!rem_done && bit_reg == 5'd0)
                begin
                    rem_start = 1'b1;
                    bit_next  = 5'd1;
                end
                else if (rem_done)
                begin
                    bit_next   = 5'd0;
                    b_next     = rem_out;
                    state_next = mau_pkg::ST_PREP;
                end
            end
            mau_pkg::ST_PREP:
            begin
                state_next = mau_pkg::ST_DONE;
                acc_next   = 31'd1;
                unique case (mau_pkg::kind_t'(kind_reg))
                    mau_pkg::KIND_REDUCE: fin_next = a_reg;
                    mau_pkg::KIND_ADD:
                    begin
                        sum_w = {1'b0, a_reg} + {1'b0, b_reg};
                        if (sum_w >= {1'b0, mod_reg})
                            sum_w = sum_w - {1'b0, mod_reg};
                        fin_next = sum_w[mau_pkg::MOD_W-1:0];
                    end
                    mau_pkg::KIND_SUB:
                        fin_next = (a_reg >= b_reg) ? a_reg - b_reg
                                                    : a_reg + (mod_reg - b_reg);
                    mau_pkg::KIND_NEG:
                        fin_next = (a_reg == '0) ? '0 : mod_reg - a_reg;
                    mau_pkg::KIND_MUL:
                    begin
                        acc_next   = a_reg;
                        sq_next    = b_reg;
                        bit_next   = 5'd0;
                        mul_start  = 1'b1;
                        mul_x      = a_reg;
                        mul_y      = b_reg;
                        state_next = mau_pkg::ST_FINAL_MUL;
                    end
                    mau_pkg::KIND_INV:
                    begin
                        if (a_reg == '0)
                            fin_next = '0;
                        else
                        begin
                            sq_next    = a_reg;
                            exp_next   = mod_reg - 31'd2;
                            bit_next   = 5'(mau_pkg::MOD_W - 1);
                            state_next = mau_pkg::ST_EXP_MUL;
                        end
                    end
                    mau_pkg::KIND_DIV:
                    begin
                        if (b_reg == '0)
                            fin_next = '0;
                        else
                        begin
                            sq_next    = b_reg;
                            exp_next   = mod_reg - 31'd2;
                            bit_next   = 5'(mau_pkg::MOD_W - 1);
                            state_next = mau_pkg::ST_EXP_MUL;
                        end
                    end
                    mau_pkg::KIND_POW:
                    begin
                        sq_next    = a_reg;
                        exp_next   = opb_reg;
                        bit_next   = 5'(mau_pkg::MOD_W - 1);
                        state_next = mau_pkg::ST_EXP_MUL;
                    end
                    default: fin_next = a_reg;
                endcase
            end
            mau_pkg::ST_EXP_MUL:
            begin
                // multiply accumulator by square when the exponent bit is set
                if (!exp_reg[0])
                    state_next = mau_pkg::ST_EXP_SQR;
                else if (!mul_done && !mbusy_reg)
                    mul_start = 1'b1;
                else if (mul_done)
                begin
                    acc_next   = mul_out;
                    state_next = mau_pkg::ST_EXP_SQR;
                end
            end
            mau_pkg::ST_EXP_SQR:
            begin
                mul_x = sq_reg;
                if (!mul_done && !mbusy_reg)
                    mul_start = 1'b1;
                else if (mul_done)
                begin
                    sq_next  = mul_out;
                    exp_next = {1'b0, exp_reg[mau_pkg::MOD_W-1:1]};
                    bit_next = bit_reg - 5'd1;
                    if (bit_reg == 5'd0)
                    begin
                        bit_next = 5'd0;
                        if (mau_pkg::kind_t'(kind_reg) == mau_pkg::KIND_DIV)
                        begin
                            sq_next    = a_reg;
                            state_next = mau_pkg::ST_FINAL_MUL;
                        end
                        else
                        begin
                            fin_next   = acc_reg;
                            state_next = mau_pkg::ST_DONE;
                        end
                    end
                    else
                        state_next = mau_pkg::ST_EXP_MUL;
                end
            end
            mau_pkg::ST_FINAL_MUL:
            begin
                // product of acc and sq; for mul the run was launched in prep
                if (!mul_done && !mbusy_reg)
                    mul_start = 1'b1;
                else if (mul_done)
                begin
                    fin_next   = mul_out;
                    state_next = mau_pkg::ST_DONE;
                end
            end
            mau_pkg::ST_DONE:
            begin
                // hand over only once the output register is free
                if (!oval_reg || !out_stall)
                begin
                    res_next   = fin_reg;
                    oval_next  = 1'b1;
                    state_next = mau_pkg::ST_IDLE;
                end
            end
            default: state_next = mau_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mbusy_next = mbusy_reg;
        if (mul_start)
            mbusy_next = 1'b1;
        else if (mul_done)
            mbusy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mau_pkg::ST_IDLE;
            mod_reg   <= mau_pkg::MODULUS_RESET;
            oval_reg  <= 1'b0;
            bit_reg   <= '0;
            mbusy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
            bit_reg   <= bit_next;
            mbusy_reg <= mbusy_next;
            if (cfg_we)
                mod_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        exp_reg  <= exp_next;
        fin_reg  <= fin_next;
        res_reg  <= res_next;
    end

    assign out_valid = oval_reg;
    assign result    = res_reg;
endmodule
